// ===== rtl/ssgd_pkg.sv =====
// Shared types and constants for the source sequence gap and duplicate detector.
// Used by the front stage, the command queue, the back stage and the top level.
// No dependencies.
package ssgd_pkg;

  // Slot numbers travel in a fixed width that covers the largest table (256 sources).
  localparam int SLOT_W = 8;
  localparam int CFG_INDEX_W = 3;
  // Power of two, so the queue pointers wrap on their own.
  localparam int QUEUE_DEPTH = 2;

  localparam logic [63:0] SEQ_MAX = '1;
  localparam logic [63:0] FIRST_ING_RESET = 64'd1;
  localparam logic [31:0] TOPIC_RESET = 32'd1;
  localparam logic [63:0] TOMB_MASK_RESET = 64'd0;
  localparam logic [63:0] TAG_MASK_RESET = '1;

  typedef enum logic [2:0] {
    KIND_DATA = 3'd0,
    KIND_TOMB = 3'd1,
    KIND_GAP  = 3'd2,
    KIND_DUP  = 3'd3,
    KIND_ERR  = 3'd4
  } kind_t;

  typedef enum logic [2:0] {
    ERR_NONE      = 3'd0,
    ERR_TOPIC     = 3'd1,
    ERR_EXHAUSTED = 3'd2,
    ERR_FULL      = 3'd3,
    ERR_POISONED  = 3'd4
  } err_t;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_TOPIC     = 3'd0,
    REG_FIRST_ING = 3'd1,
    REG_TOMB_MASK = 3'd2,
    REG_TAG_MASK  = 3'd3
  } cfg_reg_t;

  typedef enum logic [1:0] {
    CMD_ERROR  = 2'd0,
    CMD_DUP    = 2'd1,
    CMD_ACCEPT = 2'd2
  } cmd_kind_t;

  // One classified record, handed from the front stage to the back stage.
  typedef struct packed {
    cmd_kind_t         kind;
    err_t              err;
    logic              gap;
    logic              is_new;
    logic [SLOT_W-1:0] slot;
    logic [63:0]       node;
    logic [63:0]       pub;
    logic [63:0]       epoch;
    logic [63:0]       seq;
    logic [63:0]       tag;
    logic [63:0]       last;
  } cmd_t;

  typedef struct packed {
    logic poisoned;
    logic second_due;
  } back_stat_t;

  typedef struct packed {
    kind_t       kind;
    logic [63:0] ingestion;
    logic [63:0] first;
    logic [63:0] missing_end;
    logic [63:0] tag_value;
    err_t        err;
    logic        last_of_run;
  } result_t;

endpackage

// ===== rtl/ssgd_front.sv =====
// Front stage: captures a record, compares its source key against the table
// and classifies it into a command for the back stage. Depends on ssgd_pkg.
module ssgd_front import ssgd_pkg::*; #(
  parameter int SOURCES = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        take,
  input  logic [31:0] record_topic,
  input  logic [63:0] node_number,
  input  logic [63:0] publisher_number,
  input  logic [63:0] epoch_number,
  input  logic [63:0] source_seq,
  input  logic [63:0] record_tag,
  input  logic [31:0] topic_number,
  input  logic        poisoned,
  input  logic [63:0] key_node [SOURCES],
  input  logic [63:0] key_publisher [SOURCES],
  input  logic [63:0] key_epoch [SOURCES],
  input  logic [63:0] last_accepted [SOURCES],
  input  logic [SOURCES-1:0] entry_valid,
  input  logic        queue_full,
  output logic        push,
  output cmd_t        cmd,
  output logic        busy
);

  localparam int IDX_W = (SOURCES > 1) ? $clog2(SOURCES) : 1;

  logic [31:0] rec_topic;
  logic [63:0] rec_node, rec_pub, rec_epoch, rec_seq, rec_tag;
  logic        match_stage, class_stage;

  logic [SOURCES-1:0] match_c, le_c, step_c;
  logic [SOURCES-1:0] match_vec, le_vec, step_vec;

  logic             hit_found, free_found;
  logic [IDX_W-1:0] hit_idx, free_idx;

  always_ff @(posedge clk) begin
    if (rst) begin
      match_stage <= 1'b0;
      class_stage <= 1'b0;
    end else begin
      if (take) begin
        match_stage <= 1'b1;
      end else if (match_stage) begin
        match_stage <= 1'b0;
      end
      if (match_stage) begin
        class_stage <= 1'b1;
      end else if (push) begin
        class_stage <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      rec_topic <= record_topic;
      rec_node  <= node_number;
      rec_pub   <= publisher_number;
      rec_epoch <= epoch_number;
      rec_seq   <= source_seq;
      rec_tag   <= record_tag;
    end
    if (match_stage) begin
      match_vec <= match_c;
      le_vec    <= le_c;
      step_vec  <= step_c;
    end
  end

  // Every entry is compared in parallel; the flags are registered before the search.
  always_comb begin
    for (int i = 0; i < SOURCES; i++) begin
      match_c[i] = entry_valid[i] && (key_node[i] == rec_node) &&
                   (key_publisher[i] == rec_pub) && (key_epoch[i] == rec_epoch);
      le_c[i]    = rec_seq <= last_accepted[i];
      step_c[i]  = rec_seq == (last_accepted[i] + 64'd1);
    end
  end

  // The lowest matching entry wins, and a new key takes the lowest free entry.
  always_comb begin
    hit_found  = 1'b0;
    free_found = 1'b0;
    hit_idx    = '0;
    free_idx   = '0;
    for (int i = 0; i < SOURCES; i++) begin
      if (!hit_found && match_vec[i]) begin
        hit_found = 1'b1;
        hit_idx   = IDX_W'(i);
      end
      if (!free_found && !entry_valid[i]) begin
        free_found = 1'b1;
        free_idx   = IDX_W'(i);
      end
    end
  end

  always_comb begin
    cmd        = '0;
    cmd.node   = rec_node;
    cmd.pub    = rec_pub;
    cmd.epoch  = rec_epoch;
    cmd.seq    = rec_seq;
    cmd.tag    = rec_tag;
    cmd.last   = last_accepted[hit_idx];
    cmd.kind   = CMD_ERROR;
    cmd.err    = ERR_NONE;
    cmd.is_new = !hit_found;
    cmd.slot   = hit_found ? SLOT_W'(hit_idx) : SLOT_W'(free_idx);
    priority if (poisoned) begin
      cmd.err = ERR_POISONED;
    end else if (rec_topic != topic_number) begin
      cmd.err = ERR_TOPIC;
    end else if (!hit_found && !free_found) begin
      cmd.err = ERR_FULL;
    end else if (hit_found && le_vec[hit_idx]) begin
      cmd.kind = CMD_DUP;
    end else begin
      cmd.kind = CMD_ACCEPT;
      cmd.gap  = hit_found && !step_vec[hit_idx];
    end
  end

  assign push = class_stage && !queue_full;
  assign busy = match_stage || class_stage;

endmodule

// ===== rtl/ssgd_queue.sv =====
// Short command queue between the front and back stages.
// Depends on ssgd_pkg for the command type and the depth.
module ssgd_queue import ssgd_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  cmd_t push_cmd,
  input  logic pop,
  output cmd_t head_cmd,
  output logic not_empty,
  output logic full
);

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

  cmd_t             slots [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr, rd_ptr;
  logic [PTR_W:0]   count;
  logic             do_push, do_pop;

  assign do_push   = push && !full;
  assign do_pop    = pop && not_empty;
  assign not_empty = count != '0;
  assign full      = count == (PTR_W+1)'(QUEUE_DEPTH);
  assign head_cmd  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      unique case ({do_push, do_pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_cmd;
    end
  end

endmodule

// ===== rtl/ssgd_back.sv =====
// Back stage: owns the source table and the ingestion counter, carries out
// classified commands and drives one or two results each. Depends on ssgd_pkg.
module ssgd_back import ssgd_pkg::*; #(
  parameter int SOURCES = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cmd_valid,
  input  cmd_t        cmd,
  output logic        cmd_pop,
  input  logic        load_first,
  input  logic [63:0] first_value,
  input  logic [63:0] tomb_mask,
  input  logic [63:0] tag_mask,
  output logic [63:0] key_node [SOURCES],
  output logic [63:0] key_publisher [SOURCES],
  output logic [63:0] key_epoch [SOURCES],
  output logic [63:0] last_accepted [SOURCES],
  output logic [SOURCES-1:0] entry_valid,
  output back_stat_t  stat,
  output logic        result_valid,
  output result_t     result
);

  localparam int IDX_W = (SOURCES > 1) ? $clog2(SOURCES) : 1;

  typedef enum logic [1:0] {
    B_IDLE = 2'b01,
    B_DATA = 2'b10
  } back_state_t;

  back_state_t state, state_next;
  cmd_t        work;
  logic [63:0] next_ingestion;
  logic        seq_exhausted;
  logic        poisoned;
  logic [63:0] duplicate_total;

  logic             emit, take_num, fail, count_dup, claim, write_last, hold_work;
  logic [IDX_W-1:0] write_idx;
  logic [63:0]      write_seq;
  result_t          res_next;

  function automatic result_t data_result(input cmd_t c, input logic [63:0] num,
                                          input logic [63:0] tmask,
                                          input logic [63:0] vmask);
    result_t r;
    r              = '0;
    r.kind         = ((c.tag & tmask) != '0) ? KIND_TOMB : KIND_DATA;
    r.ingestion    = num;
    r.first        = c.seq;
    r.tag_value    = c.tag & vmask;
    r.err          = ERR_NONE;
    r.last_of_run  = 1'b1;
    return r;
  endfunction

  assign cmd_pop = (state == B_IDLE) && cmd_valid;

  always_comb begin
    emit       = 1'b0;
    take_num   = 1'b0;
    fail       = 1'b0;
    count_dup  = 1'b0;
    claim      = 1'b0;
    write_last = 1'b0;
    hold_work  = 1'b0;
    write_idx  = cmd.slot[IDX_W-1:0];
    write_seq  = cmd.seq;
    state_next = state;
    res_next   = '0;
    res_next.kind = KIND_ERR;
    res_next.err  = ERR_NONE;
    unique case (state)
      B_IDLE: begin
        if (cmd_valid) begin
          emit = 1'b1;
          res_next.last_of_run = 1'b1;
          unique case (cmd.kind)
            CMD_ERROR: begin
              fail         = 1'b1;
              res_next.err = cmd.err;
            end
            CMD_DUP: begin
              count_dup          = 1'b1;
              res_next.kind      = KIND_DUP;
              res_next.first     = cmd.seq;
              res_next.tag_value = cmd.tag & tag_mask;
            end
            CMD_ACCEPT: begin
              // A gap needs two numbers, so only the maximum left is not enough.
              if (seq_exhausted || (cmd.gap && next_ingestion == SEQ_MAX)) begin
                fail         = 1'b1;
                res_next.err = ERR_EXHAUSTED;
              end else if (cmd.gap) begin
                take_num             = 1'b1;
                hold_work            = 1'b1;
                state_next           = B_DATA;
                res_next.kind        = KIND_GAP;
                res_next.ingestion   = next_ingestion;
                res_next.first       = cmd.last + 64'd1;
                res_next.missing_end = cmd.seq - 64'd1;
                res_next.last_of_run = 1'b0;
              end else begin
                take_num   = 1'b1;
                claim      = cmd.is_new;
                write_last = 1'b1;
                res_next   = data_result(cmd, next_ingestion, tomb_mask, tag_mask);
              end
            end
            default: begin
              emit = 1'b0;
            end
          endcase
        end
      end
      B_DATA: begin
        emit       = 1'b1;
        take_num   = 1'b1;
        write_last = 1'b1;
        write_idx  = work.slot[IDX_W-1:0];
        write_seq  = work.seq;
        state_next = B_IDLE;
        res_next   = data_result(work, next_ingestion, tomb_mask, tag_mask);
      end
      default: begin
        state_next = B_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= B_IDLE;
      result_valid    <= 1'b0;
      entry_valid     <= '0;
      next_ingestion  <= FIRST_ING_RESET;
      seq_exhausted   <= 1'b0;
      poisoned        <= 1'b0;
      duplicate_total <= '0;
    end else begin
      state        <= state_next;
      result_valid <= emit;
      if (load_first) begin
        next_ingestion <= first_value;
        seq_exhausted  <= 1'b0;
      end else if (take_num) begin
        if (next_ingestion == SEQ_MAX) begin
          seq_exhausted <= 1'b1;
        end else begin
          next_ingestion <= next_ingestion + 64'd1;
        end
      end
      if (fail) begin
        poisoned <= 1'b1;
      end
      if (count_dup) begin
        duplicate_total <= duplicate_total + 64'd1;
      end
      if (claim) begin
        entry_valid[write_idx] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      result <= res_next;
    end
    if (hold_work) begin
      work <= cmd;
    end
    if (claim) begin
      key_node[write_idx]      <= cmd.node;
      key_publisher[write_idx] <= cmd.pub;
      key_epoch[write_idx]     <= cmd.epoch;
    end
    if (write_last) begin
      last_accepted[write_idx] <= write_seq;
    end
  end

  assign stat.poisoned   = poisoned;
  assign stat.second_due = state == B_DATA;

  a_error_poisons: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.kind == KIND_ERR |-> poisoned)
    else $error("error result without the poisoned flag");

  a_exhausted_at_max: assert property (@(posedge clk) disable iff (rst)
    seq_exhausted |-> next_ingestion == SEQ_MAX)
    else $error("ingestion counter exhausted below its maximum");

  a_second_is_data: assert property (@(posedge clk) disable iff (rst)
    state == B_DATA |=> result_valid && result.last_of_run &&
                        (result.kind == KIND_DATA || result.kind == KIND_TOMB))
    else $error("second result of a gap run is not a data beat");

endmodule

// ===== rtl/source_sequence_gap_dedup_core.sv =====
// A record passes the match register, the classification register and the command queue
// before the back stage registers its first result beat; a gap run puts its data beat in
// the cycle right after the gap beat. The next record waits until the back stage has taken
// this one, because classification reads the table.
// Reset (rst, synchronous): clears the table valid bits, the poisoned and exhausted flags,
// loads the ingestion counter with 1 and the registers with their reset values.
module source_sequence_gap_dedup_core import ssgd_pkg::*; #(
  parameter int SOURCES = 16
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   start,
  output logic                   busy,
  input  logic [31:0]            record_topic,
  input  logic [63:0]            node_number,
  input  logic [63:0]            publisher_number,
  input  logic [63:0]            epoch_number,
  input  logic [63:0]            source_seq,
  input  logic [63:0]            record_tag,
  input  logic                   cfg_write,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [63:0]            cfg_data,
  output logic                   result_valid,
  output logic [2:0]             record_kind,
  output logic [63:0]            ingestion_seq,
  output logic [63:0]            first_seq,
  output logic [63:0]            missing_end,
  output logic [63:0]            tag_value,
  output logic [2:0]             fault_code,
  output logic                   last_of_run
);

  // Configuration registers. The first ingestion number is not kept here: a write
  // to it loads the counter in the back stage directly and clears its exhausted flag.
  logic [31:0] topic_number;
  logic [63:0] tombstone_mask;
  logic [63:0] tag_value_mask;
  logic        load_first;

  // Source table, owned by the back stage and compared in parallel by the front stage.
  logic [63:0]        key_node [SOURCES];
  logic [63:0]        key_publisher [SOURCES];
  logic [63:0]        key_epoch [SOURCES];
  logic [63:0]        last_accepted [SOURCES];
  logic [SOURCES-1:0] entry_valid;

  logic       take;
  logic       front_busy;
  logic       push, pop, queue_valid, queue_full;
  cmd_t       push_cmd, head_cmd;
  back_stat_t back_stat;
  result_t    result;

  always_ff @(posedge clk) begin
    if (rst) begin
      topic_number   <= TOPIC_RESET;
      tombstone_mask <= TOMB_MASK_RESET;
      tag_value_mask <= TAG_MASK_RESET;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_TOPIC:     topic_number   <= cfg_data[31:0];
        REG_TOMB_MASK: tombstone_mask <= cfg_data;
        REG_TAG_MASK:  tag_value_mask <= cfg_data;
        default: begin
          // The first ingestion number goes to the back stage; other indexes are ignored.
        end
      endcase
    end
  end

  assign load_first = cfg_write && (cfg_index == REG_FIRST_ING);

  // The block holds one record at a time: it is busy after the beat that brings a record
  // until the back stage has taken the classified command and has no second beat due.
  assign busy = front_busy || queue_valid || back_stat.second_due;
  assign take = start && !busy;

  ssgd_front #(
    .SOURCES(SOURCES)
  ) u_front (
    .clk              (clk),
    .rst              (rst),
    .take             (take),
    .record_topic     (record_topic),
    .node_number      (node_number),
    .publisher_number (publisher_number),
    .epoch_number     (epoch_number),
    .source_seq       (source_seq),
    .record_tag       (record_tag),
    .topic_number     (topic_number),
    .poisoned         (back_stat.poisoned),
    .key_node         (key_node),
    .key_publisher    (key_publisher),
    .key_epoch        (key_epoch),
    .last_accepted    (last_accepted),
    .entry_valid      (entry_valid),
    .queue_full       (queue_full),
    .push             (push),
    .cmd              (push_cmd),
    .busy             (front_busy)
  );

  ssgd_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_cmd  (push_cmd),
    .pop       (pop),
    .head_cmd  (head_cmd),
    .not_empty (queue_valid),
    .full      (queue_full)
  );

  // The back stage turns a command into result beats and updates the table, the
  // ingestion counter, the duplicate count and the poisoned flag as it does so.
  ssgd_back #(
    .SOURCES(SOURCES)
  ) u_back (
    .clk           (clk),
    .rst           (rst),
    .cmd_valid     (queue_valid),
    .cmd           (head_cmd),
    .cmd_pop       (pop),
    .load_first    (load_first),
    .first_value   (cfg_data),
    .tomb_mask     (tombstone_mask),
    .tag_mask      (tag_value_mask),
    .key_node      (key_node),
    .key_publisher (key_publisher),
    .key_epoch     (key_epoch),
    .last_accepted (last_accepted),
    .entry_valid   (entry_valid),
    .stat          (back_stat),
    .result_valid  (result_valid),
    .result        (result)
  );

  // Result beats leave straight from the back stage's output register.
  assign record_kind   = result.kind;
  assign ingestion_seq = result.ingestion;
  assign first_seq     = result.first;
  assign missing_end   = result.missing_end;
  assign tag_value     = result.tag_value;
  assign fault_code    = result.err;
  assign last_of_run   = result.last_of_run;

  // A beat that does not close its run is always followed at once by the closing beat.
  a_run_completes: assert property (@(posedge clk) disable iff (rst)
    result_valid && !last_of_run |=> result_valid && last_of_run)
    else $error("result run left open");

  // The data beat after a gap carries the next ingestion number.
  a_gap_numbering: assert property (@(posedge clk) disable iff (rst)
    result_valid && record_kind == KIND_GAP |=> ingestion_seq == $past(ingestion_seq) + 64'd1)
    else $error("data after a gap does not take the next ingestion number");

  // Error beats, and only they, carry an error code.
  a_error_code: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (record_kind == KIND_ERR) == (fault_code != ERR_NONE))
    else $error("error code does not agree with the record kind");

endmodule
